>>> rtl/chp_pkg.sv
// Package for the compass heading block: field structs, CORDIC datapath types,
// fixed-point constants and the arctangent table.
// No dependencies; every other file of the block imports it.
package chp_pkg;

   // Number of CORDIC vectoring iterations, one pipeline stage each (8 to 24).
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;

   // Field and datapath widths.
   localparam int MAG_W  = 16;
   localparam int DIFF_W = MAG_W + 1;
   localparam int FRAC_W = 24;
   localparam int XY_W   = 44;
   localparam int ACC_W  = 26;
   localparam int HEAD_W = 17;
   localparam int RND_SH = 8;

   // Angle constants in degrees times 65536, heading wrap in degrees times 256.
   localparam logic signed [ACC_W-1:0] DEG180_Q16  = 26'sd11796480;
   localparam logic signed [ACC_W-1:0] DEG360_Q16  = 26'sd23592960;
   localparam logic        [ACC_W-1:0] ROUND_HALF  = 26'd128;
   localparam logic       [HEAD_W-1:0] HEADING_WRAP = 17'd92160;

   // atan(2^-i) in degrees times 65536, rounded to nearest.
   localparam logic signed [ACC_W-1:0] ATAN_DEG_Q16 [ATAN_ENTRIES] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
      26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
      26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
      26'sd917,     26'sd458,     26'sd229,    26'sd115,
      26'sd57,      26'sd29,      26'sd14,     26'sd7,
      26'sd4,       26'sd2,       26'sd1,      26'sd0
   };

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X = 2'd0,
      CSR_OFFSET_Y = 2'd1
   } csr_index_type;

   // Input beat: one raw sample pair.
   typedef struct packed {
      logic signed [MAG_W-1:0] mag_x;
      logic signed [MAG_W-1:0] mag_y;
   } req_data_type;

   // Result beat.
   typedef struct packed {
      logic [HEAD_W-1:0] heading;
      logic              zero_vector;
   } rsp_data_type;

   // Offset-corrected components.
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } diff_type;

   // CORDIC working vector and angle accumulator.
   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ACC_W-1:0] acc;
      logic                    zero_vector;
   } vec_type;

endpackage

>>> rtl/chp_prep.sv
// Front end of the heading pipeline: offset removal, then zero check and
// pre-rotation into the right half plane. Two register stages.
// Depends on chp_pkg.
module chp_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic signed [15:0]     offset_x,
   input  logic signed [15:0]     offset_y,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  chp_pkg::req_data_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output chp_pkg::vec_type       out_data
);
   import chp_pkg::*;

   logic     diff_valid_ff;
   diff_type diff_ff;
   diff_type diff_in;
   logic     diff_ready;

   logic     vec_valid_ff;
   vec_type  vec_ff;
   vec_type  vec_in;
   logic     vec_ready;

   logic signed [DIFF_W:0] nx;
   logic signed [DIFF_W:0] ny;

   // A stage takes a new beat when it is empty or its content moves on.
   assign vec_ready  = !vec_valid_ff || out_ready;
   assign diff_ready = !diff_valid_ff || vec_ready;
   assign in_ready   = diff_ready;

   // Stage one: subtract the hard-iron offsets; the 17-bit result is exact.
   always_comb begin
      diff_in.dx = DIFF_W'(in_data.mag_x) - DIFF_W'(offset_x);
      diff_in.dy = DIFF_W'(in_data.mag_y) - DIFF_W'(offset_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
      end else if (diff_ready) begin
         diff_valid_ff <= in_valid;
      end
      if (diff_ready && in_valid) begin
         diff_ff <= diff_in;
      end
   end

   // Stage two: a vector with negative X is turned by 180 degrees, and the
   // accumulator starts at 180 degrees to make up for it.
   always_comb begin
      nx = (DIFF_W + 1)'(diff_ff.dx);
      ny = (DIFF_W + 1)'(diff_ff.dy);
      vec_in.acc = '0;
      if (diff_ff.dx < 0) begin
         nx = -nx;
         ny = -ny;
         vec_in.acc = DEG180_Q16;
      end
      vec_in.x = XY_W'(nx) <<< FRAC_W;
      vec_in.y = XY_W'(ny) <<< FRAC_W;
      vec_in.zero_vector = (diff_ff.dx == '0) && (diff_ff.dy == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_valid_ff <= 1'b0;
      end else if (vec_ready) begin
         vec_valid_ff <= diff_valid_ff;
      end
      if (vec_ready && diff_valid_ff) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = vec_valid_ff;
   assign out_data  = vec_ff;

endmodule

>>> rtl/chp_cordic.sv
// CORDIC vectoring pipeline: one register stage per iteration, each stage
// one add and one subtract on the vector plus one table add on the angle.
// Depends on chp_pkg.
module chp_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  chp_pkg::vec_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output chp_pkg::vec_type  out_data
);
   import chp_pkg::*;

   // Link k feeds stage k; link CORDIC_STEPS is the pipeline output.
   vec_type link_vec   [CORDIC_STEPS+1];
   logic    link_valid [CORDIC_STEPS+1];
   logic    link_ready [CORDIC_STEPS+1];

   assign link_vec[0]   = in_data;
   assign link_valid[0] = in_valid;
   assign in_ready      = link_ready[0];

   assign link_ready[CORDIC_STEPS] = out_ready;
   assign out_valid = link_valid[CORDIC_STEPS];
   assign out_data  = link_vec[CORDIC_STEPS];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic    stage_valid_ff;
      vec_type stage_ff;
      vec_type stage_in;
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;

      assign link_ready[k] = !stage_valid_ff || link_ready[k+1];

      // Rotate toward the X axis; both updates use the old vector.
      always_comb begin
         xs = link_vec[k].x >>> k;
         ys = link_vec[k].y >>> k;
         stage_in.zero_vector = link_vec[k].zero_vector;
         if (!link_vec[k].y[XY_W-1] && (link_vec[k].y != '0)) begin
            stage_in.x   = link_vec[k].x + ys;
            stage_in.y   = link_vec[k].y - xs;
            stage_in.acc = link_vec[k].acc + ATAN_DEG_Q16[k];
         end else begin
            stage_in.x   = link_vec[k].x - ys;
            stage_in.y   = link_vec[k].y + xs;
            stage_in.acc = link_vec[k].acc - ATAN_DEG_Q16[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_valid_ff <= 1'b0;
         end else if (link_ready[k]) begin
            stage_valid_ff <= link_valid[k];
         end
         if (link_ready[k] && link_valid[k]) begin
            stage_ff <= stage_in;
         end
      end

      assign link_valid[k+1] = stage_valid_ff;
      assign link_vec[k+1]   = stage_ff;
   end

endmodule

>>> rtl/chp_post.sv
// Back end of the heading pipeline: fold the angle into [0, 360), round to
// 8 fraction bits; the output register maps 360 and a zero vector to 0.
// Depends on chp_pkg.
module chp_post (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  chp_pkg::vec_type      in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output chp_pkg::rsp_data_type out_data
);
   import chp_pkg::*;

   logic         rnd_valid_ff;
   rsp_data_type rnd_ff;
   rsp_data_type rnd_in;
   logic         rnd_ready;

   logic         rsp_valid_ff;
   rsp_data_type rsp_ff;
   rsp_data_type rsp_in;
   logic         rsp_ready;

   logic [ACC_W-1:0] acc_pos;
   logic [ACC_W-1:0] acc_rnd;

   assign rsp_ready = !rsp_valid_ff || out_ready;
   assign rnd_ready = !rnd_valid_ff || rsp_ready;
   assign in_ready  = rnd_ready;

   // Add a full turn to a negative angle, then round to nearest.
   always_comb begin
      acc_pos = in_data.acc[ACC_W-1] ? ACC_W'(in_data.acc + DEG360_Q16)
                                     : ACC_W'(in_data.acc);
      acc_rnd = acc_pos + ROUND_HALF;
      rnd_in.heading     = acc_rnd[RND_SH +: HEAD_W];
      rnd_in.zero_vector = in_data.zero_vector;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (rnd_ready) begin
         rnd_valid_ff <= in_valid;
      end
      if (rnd_ready && in_valid) begin
         rnd_ff <= rnd_in;
      end
   end

   // A heading that rounds up to 360 degrees becomes 0; a zero vector reads 0.
   always_comb begin
      rsp_in.zero_vector = rnd_ff.zero_vector;
      if (rnd_ff.zero_vector) begin
         rsp_in.heading = '0;
      end else if (rnd_ff.heading >= HEADING_WRAP) begin
         rsp_in.heading = rnd_ff.heading - HEADING_WRAP;
      end else begin
         rsp_in.heading = rnd_ff.heading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= rnd_valid_ff;
      end
      if (rsp_ready && rnd_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

>>> rtl/compass_heading_from_field.sv
// Top level of the compass heading block: offset registers, the pipeline
// front end, the CORDIC stages and the output stages.
// Depends on chp_pkg, chp_prep, chp_cordic and chp_post.
//
//   Channel  Direction  Ports                           Beat
//   req      in         req_valid, req_ready, req_data  raw mag_x, mag_y pair
//   rsp      out        rsp_valid, rsp_ready, rsp_data  heading, zero_vector
//   csr      in         csr_wr_en, csr_index, csr_wdata offset_x (0), offset_y (1)
//
// There are two front-end stages, one stage per CORDIC iteration and two output
// stages. The rate, set by the one-iteration stages, is one beat per cycle
// while the pipeline is not full behind a stalled output.
// Reset clears every stage valid bit and both offsets.
// Each stage holds its beat while the next one is full and stalled, and
// an empty stage fills even when the output is stalled.
module compass_heading_from_field (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  chp_pkg::req_data_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output chp_pkg::rsp_data_type             rsp_data,
   input  logic                              csr_wr_en,
   input  logic [chp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [chp_pkg::MAG_W-1:0]         csr_wdata
);
   import chp_pkg::*;

   logic signed [MAG_W-1:0] offset_x_ff;
   logic signed [MAG_W-1:0] offset_y_ff;

   logic    prep_valid;
   logic    prep_ready;
   vec_type prep_data;
   logic    cordic_valid;
   logic    cordic_ready;
   vec_type cordic_data;

   // Offset registers; an index outside the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OFFSET_X: offset_x_ff <= csr_wdata;
            CSR_OFFSET_Y: offset_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   chp_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .offset_x  (offset_x_ff),
      .offset_y  (offset_y_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   chp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (cordic_valid),
      .out_ready (cordic_ready),
      .out_data  (cordic_data)
   );

   chp_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cordic_valid),
      .in_ready  (cordic_ready),
      .in_data   (cordic_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // A full pipeline is the only reason to refuse a beat, and only a stalled
   // output fills it.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input refused while the output is not stalled");

   // The heading always lies below 360 degrees.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.heading < HEADING_WRAP))
      else $error("heading outside [0, 360)");

   // A zero vector always reports heading 0.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_vector) |-> (rsp_data.heading == '0))
      else $error("zero vector with nonzero heading");

   // Nothing comes out in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
